@@ src/rectangle_canvas_painter_unit_assert.svh @@
// Assertion macros for the rectangle canvas painter.
`ifndef RECTANGLE_CANVAS_PAINTER_UNIT_ASSERT_SVH
`define RECTANGLE_CANVAS_PAINTER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define RCP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define RCP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/rcp_pkg.sv @@
// Shared constants, types and helpers for the rectangle canvas painter.
`default_nettype none
package rcp_pkg;

  localparam int unsigned MAX_WIDTH  = 256;
  localparam int unsigned MAX_HEIGHT = 256;
  localparam int unsigned FRAC_BITS  = 8;

  localparam int unsigned COORD_W = 24;
  localparam int unsigned CFG_W   = 9;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned SEL_W   = 8;

  localparam int unsigned COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned IDX_W = (COL_W > ROW_W) ? COL_W : ROW_W;

  localparam int unsigned DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Room for pixel positions, edges and their differences without overflow.
  localparam int unsigned POS_W = ((COORD_W > IDX_W + FRAC_BITS) ? COORD_W
                                   : IDX_W + FRAC_BITS);
  localparam int unsigned EXT_W = POS_W + 3;

  localparam logic signed [EXT_W-1:0] FIX_ONE =
    {{(EXT_W-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_DRAW  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] REG_CANVAS_WIDTH  = 2'd0;
  localparam logic [1:0] REG_CANVAS_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BACKGROUND    = 2'd2;

  localparam logic [CHAR_W-1:0] MODE_FILLED  = 8'h52;
  localparam logic [CHAR_W-1:0] MODE_OUTLINE = 8'h72;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_DRAW,
    ST_READ,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic outside;
    logic near;
  } axis_flags_t;

  // Last usable index for a size register: 0 counts as 1, large values saturate.
  function automatic logic [IDX_W-1:0] last_index(input logic [CFG_W-1:0] v,
                                                  input int unsigned maxv);
    logic [IDX_W-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (32'(v) > maxv) begin
      r = IDX_W'(maxv - 32'd1);
    end else begin
      r = IDX_W'(32'(v) - 32'd1);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ src/rcp_canvas_ram.sv @@
// Canvas character memory: one write port, one registered read port.
`default_nettype none
module rcp_canvas_ram (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [rcp_pkg::ADDR_W-1:0]  waddr,
  input  wire logic [rcp_pkg::CHAR_W-1:0]  wdata,
  input  wire logic [rcp_pkg::ADDR_W-1:0]  raddr,
  output logic      [rcp_pkg::CHAR_W-1:0]  rdata
);

  logic [rcp_pkg::CHAR_W-1:0] mem [rcp_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ src/rcp_axis_cmp.sv @@
// One-axis edge compare: outside test and within-one-unit-of-edge test.
`default_nettype none
module rcp_axis_cmp (
  input  wire logic        [rcp_pkg::IDX_W-1:0] idx,
  input  wire logic signed [rcp_pkg::EXT_W-1:0] lo,
  input  wire logic signed [rcp_pkg::EXT_W-1:0] hi,
  output rcp_pkg::axis_flags_t                  flags
);

  logic signed [rcp_pkg::EXT_W-1:0] pos;
  logic signed [rcp_pkg::EXT_W-1:0] d_lo;
  logic signed [rcp_pkg::EXT_W-1:0] d_hi;

  // pixel index placed at idx.0 in fixed point
  assign pos  = signed'(rcp_pkg::EXT_W'({idx, {rcp_pkg::FRAC_BITS{1'b0}}}));
  assign d_lo = pos - lo;
  assign d_hi = hi - pos;

  assign flags.outside = d_lo[rcp_pkg::EXT_W-1] | d_hi[rcp_pkg::EXT_W-1];
  assign flags.near    = (d_lo < rcp_pkg::FIX_ONE) | (d_hi < rcp_pkg::FIX_ONE);

endmodule
`default_nettype wire

@@ src/rectangle_canvas_painter_unit.sv @@
// Top level of the rectangle canvas painter: sequencer, scan counters and canvas.
//
// Usage:
// Config port: cfg_we writes cfg_data into register cfg_index (0 width,
// 1 height, 2 background char) at the clock edge; write only while idle.
// Input channel in_valid/in_ready carries one command item; in_ready is high
// only while the sequencer is idle. Output channel out_valid/out_ready returns
// exactly one result item (status, pixel_char) per command.
// Clear and draw walk the canvas one pixel per cycle through the single
// memory write port and the two axis compare units, then pass through the
// finish step; a new item is taken only once the sequencer is back in idle.
// A read goes through the read step, where the registered memory read
// fetches the pixel, then the finish step, which loads out_valid; a rejected
// draw, an off-canvas read or an unused opcode goes straight to the finish step.
// A finished result sits in the output register; the sequencer returns to
// idle and accepts the next item while it waits, but holds the next result
// in its finish step until out_ready drains the register.
// Reset (rst, synchronous) returns to idle, drops out_valid and loads the
// register defaults; canvas contents are undefined until cleared or drawn.
`default_nettype none
`include "rectangle_canvas_painter_unit_assert.svh"
module rectangle_canvas_painter_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [1:0]                          cfg_index,
  input  wire logic [rcp_pkg::CFG_W-1:0]           cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [1:0]                          opcode,
  input  wire logic [rcp_pkg::CHAR_W-1:0]          mode_char,
  input  wire logic signed [rcp_pkg::COORD_W-1:0]  rect_x,
  input  wire logic signed [rcp_pkg::COORD_W-1:0]  rect_y,
  input  wire logic signed [rcp_pkg::COORD_W-1:0]  rect_w,
  input  wire logic signed [rcp_pkg::COORD_W-1:0]  rect_h,
  input  wire logic [rcp_pkg::CHAR_W-1:0]          paint_char,
  input  wire logic [rcp_pkg::SEL_W-1:0]           read_row,
  input  wire logic [rcp_pkg::SEL_W-1:0]           read_col,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic                                     status,
  output logic [rcp_pkg::CHAR_W-1:0]               pixel_char
);

  // configuration
  logic [rcp_pkg::CFG_W-1:0]  canvas_width;
  logic [rcp_pkg::CFG_W-1:0]  canvas_height;
  logic [rcp_pkg::CHAR_W-1:0] background_char;

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width    <= rcp_pkg::CFG_W'(1);
      canvas_height   <= rcp_pkg::CFG_W'(1);
      background_char <= rcp_pkg::CHAR_W'(32);
    end else if (cfg_we) begin
      case (cfg_index)
        rcp_pkg::REG_CANVAS_WIDTH:  canvas_width    <= cfg_data;
        rcp_pkg::REG_CANVAS_HEIGHT: canvas_height   <= cfg_data;
        rcp_pkg::REG_BACKGROUND:    background_char <= cfg_data[rcp_pkg::CHAR_W-1:0];
        default: ;
      endcase
    end
  end

  rcp_pkg::state_t state, state_next;

  logic [rcp_pkg::COL_W-1:0]        scan_col, last_col;
  logic [rcp_pkg::ROW_W-1:0]        scan_row, last_row;
  logic signed [rcp_pkg::EXT_W-1:0] lo_x, hi_x, lo_y, hi_y;
  logic [rcp_pkg::CHAR_W-1:0]       paint;
  logic                             mode_filled;
  logic [rcp_pkg::ADDR_W-1:0]       rd_addr;
  logic                             res_status;
  logic                             read_hit;

  logic                             accept;
  logic                             load_out;
  logic                             ram_we;
  logic [rcp_pkg::CHAR_W-1:0]       ram_wdata;
  logic [rcp_pkg::ADDR_W-1:0]       wr_addr;
  logic [rcp_pkg::CHAR_W-1:0]       ram_rdata;
  logic                             scan_last;
  logic                             draw_bad;
  logic                             read_in;
  logic [rcp_pkg::COL_W-1:0]        last_col_in;
  logic [rcp_pkg::ROW_W-1:0]        last_row_in;
  rcp_pkg::axis_flags_t             fx, fy;
  logic                             pix_hit;

  assign last_col_in = rcp_pkg::COL_W'(rcp_pkg::last_index(canvas_width,
                                                           rcp_pkg::MAX_WIDTH));
  assign last_row_in = rcp_pkg::ROW_W'(rcp_pkg::last_index(canvas_height,
                                                           rcp_pkg::MAX_HEIGHT));

  assign draw_bad = rect_w[rcp_pkg::COORD_W-1] || (rect_w == '0) ||
                    rect_h[rcp_pkg::COORD_W-1] || (rect_h == '0) ||
                    ((mode_char != rcp_pkg::MODE_FILLED) &&
                     (mode_char != rcp_pkg::MODE_OUTLINE));
  assign read_in  = (32'(read_row) <= 32'(last_row_in)) &&
                    (32'(read_col) <= 32'(last_col_in));

  assign accept    = in_valid && in_ready;
  assign scan_last = (scan_col == last_col) && (scan_row == last_row);

  // per-pixel classification, one pixel per cycle
  rcp_axis_cmp u_cmp_x (
    .idx   (rcp_pkg::IDX_W'(scan_col)),
    .lo    (lo_x),
    .hi    (hi_x),
    .flags (fx)
  );

  rcp_axis_cmp u_cmp_y (
    .idx   (rcp_pkg::IDX_W'(scan_row)),
    .lo    (lo_y),
    .hi    (hi_y),
    .flags (fy)
  );

  assign pix_hit = !(fx.outside || fy.outside) && (mode_filled || fx.near || fy.near);

  assign wr_addr = rcp_pkg::ADDR_W'(scan_row) * rcp_pkg::ADDR_W'(rcp_pkg::MAX_WIDTH)
                 + rcp_pkg::ADDR_W'(scan_col);

  rcp_canvas_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rcp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    ram_we     = 1'b0;
    ram_wdata  = paint;
    load_out   = 1'b0;
    unique case (state)
      rcp_pkg::ST_IDLE: begin
        in_ready = !rst;
        if (in_valid) begin
          unique case (opcode)
            rcp_pkg::OP_CLEAR: state_next = rcp_pkg::ST_CLEAR;
            rcp_pkg::OP_DRAW:  state_next = draw_bad ? rcp_pkg::ST_FINISH
                                                     : rcp_pkg::ST_DRAW;
            rcp_pkg::OP_READ:  state_next = read_in ? rcp_pkg::ST_READ
                                                    : rcp_pkg::ST_FINISH;
            default:           state_next = rcp_pkg::ST_FINISH;
          endcase
        end
      end
      rcp_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = background_char;
        if (scan_last) state_next = rcp_pkg::ST_FINISH;
      end
      rcp_pkg::ST_DRAW: begin
        ram_we = pix_hit;
        if (scan_last) state_next = rcp_pkg::ST_FINISH;
      end
      rcp_pkg::ST_READ: begin
        state_next = rcp_pkg::ST_FINISH;
      end
      rcp_pkg::ST_FINISH: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = rcp_pkg::ST_IDLE;
        end
      end
      default: state_next = rcp_pkg::ST_IDLE;
    endcase
  end

  // command registers, latched at accept
  always_ff @(posedge clk) begin
    if (accept) begin
      last_col    <= last_col_in;
      last_row    <= last_row_in;
      lo_x        <= rcp_pkg::EXT_W'(rect_x);
      hi_x        <= rcp_pkg::EXT_W'(rect_x) + rcp_pkg::EXT_W'(rect_w);
      lo_y        <= rcp_pkg::EXT_W'(rect_y);
      hi_y        <= rcp_pkg::EXT_W'(rect_y) + rcp_pkg::EXT_W'(rect_h);
      paint       <= paint_char;
      mode_filled <= (mode_char == rcp_pkg::MODE_FILLED);
      rd_addr     <= rcp_pkg::ADDR_W'(read_row) * rcp_pkg::ADDR_W'(rcp_pkg::MAX_WIDTH)
                   + rcp_pkg::ADDR_W'(read_col);
      res_status  <= (opcode == rcp_pkg::OP_DRAW) && draw_bad;
      read_hit    <= (opcode == rcp_pkg::OP_READ) && read_in;
    end
  end

  // raster counters, row-major
  always_ff @(posedge clk) begin
    if (rst || accept) begin
      scan_col <= '0;
      scan_row <= '0;
    end else if (state == rcp_pkg::ST_CLEAR || state == rcp_pkg::ST_DRAW) begin
      if (scan_col == last_col) begin
        scan_col <= '0;
        scan_row <= scan_row + rcp_pkg::ROW_W'(1);
      end else begin
        scan_col <= scan_col + rcp_pkg::COL_W'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      status     <= res_status;
      pixel_char <= read_hit ? ram_rdata : '0;
    end
  end

  `RCP_ASSERT_IMP(a_scan_in_canvas,
    (state == rcp_pkg::ST_CLEAR) || (state == rcp_pkg::ST_DRAW),
    (scan_col <= last_col) && (scan_row <= last_row),
    "scan counter ran past the canvas")
  `RCP_ASSERT_IMP(a_write_only_in_scan,
    ram_we,
    (state == rcp_pkg::ST_CLEAR) || (state == rcp_pkg::ST_DRAW),
    "canvas written outside a scan")
  `RCP_ASSERT_NXT(a_bad_draw_skipped,
    accept && (opcode == rcp_pkg::OP_DRAW) && draw_bad,
    (state == rcp_pkg::ST_FINISH) && res_status,
    "rejected draw did not go straight to finish")
  `RCP_ASSERT_IMP(a_error_has_no_pixel,
    out_valid && status,
    pixel_char == '0,
    "error result carries a pixel")

endmodule
`default_nettype wire
